// File: src/irmq_pkg.sv
// Shared constants, types and codes for the insert and range-minimum sequence core.
package irmq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;

    localparam logic signed [DATA_W-1:0] LARGEST_VALUE = 32'sh7fff_ffff;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic                     ins_en;
        logic [IDX_W-1:0]         ins_pos;
        logic signed [DATA_W-1:0] ins_value;
        logic [IDX_W-1:0]         lo;
        logic [IDX_W-1:0]         hi;
    } cell_ctl_t;

endpackage

// File: src/irmq_cell.sv
// One storage cell: holds an entry, shifts up on insert, carries the running minimum.
module irmq_cell
(
    input  logic                             clk,
    input  logic [irmq_pkg::IDX_W-1:0]       idx,
    input  irmq_pkg::cell_ctl_t              ctl,
    input  logic signed [irmq_pkg::DATA_W-1:0] prev_val,
    input  logic signed [irmq_pkg::DATA_W-1:0] prev_min,
    output logic signed [irmq_pkg::DATA_W-1:0] val,
    output logic signed [irmq_pkg::DATA_W-1:0] acc
);

    logic signed [irmq_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [irmq_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic signed [irmq_pkg::DATA_W-1:0] masked;

    // Insert: cells above the slot take their lower neighbour, the slot takes the value
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins_en)
        begin
            if (idx > ctl.ins_pos)
                val_next = prev_val;
            else if (idx == ctl.ins_pos)
                val_next = ctl.ins_value;
        end
    end

    // Running minimum wave, one cell per cycle
    always_comb
    begin
        masked   = (idx >= ctl.lo && idx <= ctl.hi) ? val_reg : irmq_pkg::LARGEST_VALUE;
        acc_next = (masked < prev_min) ? masked : prev_min;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        acc_reg <= acc_next;
    end

    assign val = val_reg;
    assign acc = acc_reg;

endmodule

// File: src/insert_and_range_min_sequence_core.sv
// Top level: ordered sequence store with positional insert and range-minimum query.
//
// Items arrive on the s_ channel: tuser carries the request kind (0 insert,
// 1 range-minimum query), tdata the positions and the value. One result item
// per request leaves on the m_ channel.
// The store is a row of 1024 cells. An insert shifts the cells above the
// slot up by one in the cycle the item is accepted; its result then passes
// through the DONE state into the output register; the next item is taken once
// the core is back in IDLE. Refused or empty queries behave the same way.
// A query sends a running minimum along the row, one cell per cycle, so a
// valid query passes through the SCAN and DONE states before its result
// reaches the output register, and the next item is taken back in IDLE.
// One item is in work at a time; the next one is accepted as soon as the
// previous result sits in the output register, even while it waits there.
// A stalled receiver holds m_tdata stable; once the output register and the
// pending result are both full, s_tready stays low.
// Reset (rst_n low, asynchronous) empties the sequence; cell contents are not
// cleared, since only written positions are ever read.
module insert_and_range_min_sequence_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pos_a[10:0], pos_b[21:11], value[53:22], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // min_value[31:0], range_empty[32], status[34:33], zero pad
);

    localparam int N = irmq_pkg::CAPACITY;

    irmq_pkg::fsm_t state_reg, state_next;
    logic [irmq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [irmq_pkg::CNT_W-1:0] scan_reg, scan_next;
    logic [irmq_pkg::IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [irmq_pkg::DATA_W-1:0] res_min_reg, res_min_next;
    logic res_empty_reg, res_empty_next;
    logic [1:0] res_status_reg, res_status_next;
    logic out_valid_reg, out_valid_next;
    logic [34:0] out_data_reg, out_data_next;

    logic accept, out_free;
    logic [irmq_pkg::POS_W-1:0] pos_a, pos_b, start;
    logic signed [irmq_pkg::DATA_W-1:0] in_value;
    logic ins_ok;
    irmq_pkg::cell_ctl_t ctl;

    logic signed [irmq_pkg::DATA_W-1:0] vals [N];
    logic signed [irmq_pkg::DATA_W-1:0] accs [N];

    assign pos_a    = s_tdata[10:0];
    assign pos_b    = s_tdata[21:11];
    assign in_value = s_tdata[53:22];
    assign start    = (pos_a == '0) ? irmq_pkg::POS_W'(1) : pos_a;

    assign s_tready = (state_reg == irmq_pkg::FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign ins_ok   = accept && s_tuser == irmq_pkg::REQ_INSERT
                      && count_reg != irmq_pkg::CNT_W'(N) && pos_a <= count_reg;

    // Cell row control
    always_comb
    begin
        ctl.ins_en    = ins_ok;
        ctl.ins_pos   = pos_a[irmq_pkg::IDX_W-1:0];
        ctl.ins_value = in_value;
        ctl.lo        = lo_reg;
        ctl.hi        = hi_reg;
    end

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            irmq_cell u_cell
            (
                .clk      (clk),
                .idx      (irmq_pkg::IDX_W'(gi)),
                .ctl      (ctl),
                .prev_val ((gi == 0) ? in_value : vals[(gi == 0) ? 0 : gi - 1]),
                .prev_min ((gi == 0) ? irmq_pkg::LARGEST_VALUE : accs[(gi == 0) ? 0 : gi - 1]),
                .val      (vals[gi]),
                .acc      (accs[gi])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irmq_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == irmq_pkg::REQ_QUERY && pos_b <= count_reg
                        && start <= pos_b)
                        state_next = irmq_pkg::FSM_SCAN;
                    else
                        state_next = irmq_pkg::FSM_DONE;
                end
            end
            irmq_pkg::FSM_SCAN:
            begin
                if (scan_reg == irmq_pkg::CNT_W'(N))
                    state_next = irmq_pkg::FSM_DONE;
            end
            irmq_pkg::FSM_DONE:
            begin
                if (out_free)
                    state_next = irmq_pkg::FSM_IDLE;
            end
            default: state_next = irmq_pkg::FSM_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        scan_next       = scan_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_min_next    = res_min_reg;
        res_empty_next  = res_empty_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        case (state_reg)
            irmq_pkg::FSM_IDLE:
            begin
                scan_next = '0;
                if (accept)
                begin
                    res_min_next = irmq_pkg::LARGEST_VALUE;
                    res_empty_next = 1'b0;
                    res_status_next = irmq_pkg::ST_OK;
                    if (s_tuser == irmq_pkg::REQ_INSERT)
                    begin
                        if (count_reg == irmq_pkg::CNT_W'(N))
                            res_status_next = irmq_pkg::ST_FULL;
                        else if (pos_a > count_reg)
                            res_status_next = irmq_pkg::ST_POS;
                        else
                            count_next = count_reg + 1'b1;
                    end
                    else if (pos_b > count_reg)
                    begin
                        res_status_next = irmq_pkg::ST_POS;
                        res_empty_next = 1'b1;
                    end
                    else if (start > pos_b)
                        res_empty_next = 1'b1;
                    lo_next = irmq_pkg::IDX_W'(start - 1'b1);
                    hi_next = irmq_pkg::IDX_W'(pos_b - 1'b1);
                end
            end
            irmq_pkg::FSM_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == irmq_pkg::CNT_W'(N))
                    res_min_next = accs[N-1];
            end
            irmq_pkg::FSM_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_status_reg, res_empty_reg, res_min_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irmq_pkg::FSM_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_min_reg    <= res_min_next;
        res_empty_reg  <= res_empty_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= irmq_pkg::CNT_W'(N))
        else $error("entry count beyond capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the sequence");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == irmq_pkg::FSM_SCAN |-> scan_reg <= irmq_pkg::CNT_W'(N))
        else $error("scan counter overran");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_data_reg) && out_valid_reg)
        else $error("stalled result changed");

endmodule
